>>> rtl/core/lcfc_pkg.sv
// Types and constants shared by the LED colour fade controller.
// No dependencies.
package lcfc_pkg;

  // Request commands
  typedef enum logic [1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_POWER      = 2'd1,
    CMD_WHITE_MODE = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  // Hue difference at or above this steps down round the circle
  localparam logic [7:0] HALF_CIRCLE = 8'd128;

  // One request
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] hue_in;
    logic [7:0] value_in;
    logic [7:0] white_in;
    logic       flag_in;
  } req_t;

  // One strip update
  typedef struct packed {
    logic       show_white;
    logic [7:0] hue_out;
    logic [7:0] value_out;
    logic [7:0] white_out;
  } upd_t;

endpackage

>>> rtl/core/lcfc_core.sv
// Colour state and fade step logic of the LED colour fade controller.
// Depends on lcfc_pkg.
module lcfc_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  lcfc_pkg::req_t req,
  output logic           res_valid,
  output lcfc_pkg::upd_t res
);
  import lcfc_pkg::*;

  logic [7:0] target_hue, target_value, target_white;
  logic [7:0] current_hue, current_value, current_white;
  logic       power_on, white_mode;

  logic [7:0] target_hue_next, target_value_next, target_white_next;
  logic [7:0] current_hue_next, current_value_next, current_white_next;
  logic       power_on_next, white_mode_next;

  logic [7:0] hue_diff;
  logic [7:0] hue_step, value_step, white_step;

  function automatic upd_t colour_upd(input logic [7:0] hue, input logic [7:0] value);
    upd_t u;
    u.show_white = 1'b0;
    u.hue_out    = hue;
    u.value_out  = value;
    u.white_out  = 8'd0;
    return u;
  endfunction

  // White level 0 is shown as colour 0/0
  function automatic upd_t white_upd(input logic [7:0] level);
    upd_t u;
    if (level == 8'd0) begin
      u = colour_upd(8'd0, 8'd0);
    end else begin
      u.show_white = 1'b1;
      u.hue_out    = 8'd0;
      u.value_out  = 8'd0;
      u.white_out  = level;
    end
    return u;
  endfunction

  function automatic logic [7:0] step_linear(input logic [7:0] cur, input logic [7:0] tgt);
    logic [7:0] r;
    if (tgt > cur) begin
      r = cur + 8'd1;
    end else if (tgt < cur) begin
      r = cur - 8'd1;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // Fade step candidates
  always_comb begin
    hue_diff = target_hue - current_hue;
    if (hue_diff >= HALF_CIRCLE) begin
      hue_step = current_hue - 8'd1;
    end else if (hue_diff != 8'd0) begin
      hue_step = current_hue + 8'd1;
    end else begin
      hue_step = current_hue;
    end
    value_step = step_linear(current_value, target_value);
    white_step = step_linear(current_white, target_white);
  end

  // Command decode: next state and update
  always_comb begin
    target_hue_next    = target_hue;
    target_value_next  = target_value;
    target_white_next  = target_white;
    current_hue_next   = current_hue;
    current_value_next = current_value;
    current_white_next = current_white;
    power_on_next      = power_on;
    white_mode_next    = white_mode;
    res_valid          = 1'b0;
    res                = colour_upd(8'd0, 8'd0);

    if (fire) begin
      case (cmd_t'(req.command))
        CMD_SET_TARGET: begin
          if (white_mode) begin
            target_white_next = req.white_in;
          end else begin
            target_hue_next   = req.hue_in;
            target_value_next = req.value_in;
          end
        end
        CMD_POWER: begin
          if (!req.flag_in && power_on) begin
            power_on_next = 1'b0;
            res_valid     = 1'b1;
            res           = colour_upd(8'd0, 8'd0);
          end else if (req.flag_in && !power_on) begin
            power_on_next = 1'b1;
            res_valid     = 1'b1;
            res           = white_mode ? white_upd(target_white)
                                       : colour_upd(target_hue, target_value);
          end
        end
        CMD_WHITE_MODE: begin
          if (!req.flag_in && white_mode) begin
            white_mode_next = 1'b0;
            res_valid       = 1'b1;
            res             = colour_upd(target_hue, target_value);
          end else if (req.flag_in && !white_mode) begin
            white_mode_next = 1'b1;
            res_valid       = 1'b1;
            res             = white_upd(target_white);
          end
        end
        CMD_TICK: begin
          // power flag deliberately not checked
          if (!white_mode) begin
            if (target_hue != current_hue || target_value != current_value) begin
              current_hue_next   = hue_step;
              current_value_next = value_step;
              res_valid          = 1'b1;
              res                = colour_upd(hue_step, value_step);
            end
          end else if (target_white != current_white) begin
            current_white_next = white_step;
            res_valid          = 1'b1;
            res                = white_upd(white_step);
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_hue    <= 8'd0;
      target_value  <= 8'd0;
      target_white  <= 8'd0;
      current_hue   <= 8'd0;
      current_value <= 8'd0;
      current_white <= 8'd0;
      power_on      <= 1'b0;
      white_mode    <= 1'b0;
    end else begin
      target_hue    <= target_hue_next;
      target_value  <= target_value_next;
      target_white  <= target_white_next;
      current_hue   <= current_hue_next;
      current_value <= current_value_next;
      current_white <= current_white_next;
      power_on      <= power_on_next;
      white_mode    <= white_mode_next;
    end
  end

endmodule

>>> rtl/core/led_color_fade_controller.sv
// Top level of the LED colour fade controller: request register, fade core, update buffer.
// Depends on lcfc_pkg and lcfc_core.

// Accepts one request every clock while req_stall is low. A request is
// registered, then decoded by the fade core once the skid register is empty;
// the core updates the colour state and, where the shown strip changes, writes
// one update into a two-entry output buffer (output register plus skid
// register); updates are offered from the output register. The request side stalls
// only while a registered request is held and both buffer entries are full, so
// a stalled update side absorbs one more request before back-pressure reaches it.
module led_color_fade_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lcfc_pkg::req_t req,
  output logic           upd_valid,
  input  logic           upd_stall,
  output lcfc_pkg::upd_t upd
);
  import lcfc_pkg::*;

  logic s1_valid;
  req_t s1_req;
  logic s1_advance;
  logic res_valid;
  upd_t res;
  logic skid_valid;
  upd_t skid;
  logic pop;

  assign s1_advance = s1_valid && !skid_valid;
  assign req_stall  = s1_valid && skid_valid;
  assign pop        = upd_valid && !upd_stall;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_req <= req;
    end
  end

  lcfc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (s1_advance),
    .req      (s1_req),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!upd_valid || pop) begin
      if (skid_valid) begin
        upd_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        upd_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!upd_valid || pop) begin
      if (skid_valid) begin
        upd <= skid;
      end else if (res_valid) begin
        upd <= res;
      end
    end else if (res_valid) begin
      skid <= res;
    end
  end

`ifndef SYNTHESIS
  // skid entry is only ever occupied behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> upd_valid)
    else $error("skid entry full with output register empty");

  // a taken update never leaves the skid entry filled
  a_pop_drains_skid: assert property (@(posedge clk) disable iff (rst)
    pop |=> !skid_valid)
    else $error("skid entry still full after an update was taken");

  // white updates carry a nonzero level, colour updates none
  a_white_level: assert property (@(posedge clk) disable iff (rst)
    upd_valid |-> (upd.show_white ? (upd.white_out != 8'd0) : (upd.white_out == 8'd0)))
    else $error("white level inconsistent with update kind");
`endif

endmodule
